// File: src/set_assoc_lru_cache_tags_defines.svh
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_defines
// Assertion macros for the cache tag block.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every edge outside reset
`define SACL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition in one cycle implies a result in the next
`define SACL_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SACL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SACL_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// File: src/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the cache tag and LRU block.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int TAG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int SET_OUT_W  = 8;
    localparam int WAY_OUT_W  = 3;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    // way count after clamping, up to 15
    localparam int WAYS_CNT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd5;
    localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 4'd6;
    localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = 4'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

endpackage

// File: src/sacl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sacl_way_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_way_sel
// Tag compare across the ways of one set and LRU victim choice.
// ----------------------------------------------------------------------------
module sacl_way_sel #(
    parameter int MAX_WAYS   = 8,
    parameter int STAMP_BITS = 32,
    parameter int WAY_W      = 3
) (
    input  logic [MAX_WAYS*sacl_pkg::TAG_W-1:0] i_tags,
    input  logic [MAX_WAYS*STAMP_BITS-1:0]      i_stamps,
    input  logic [sacl_pkg::TAG_W-1:0]          i_tag,
    input  logic [sacl_pkg::WAYS_CNT_W-1:0]     i_ways,
    output logic                                o_hit,
    output logic [WAY_W-1:0]                    o_way
);

    localparam int LEAVES = 2 ** WAY_W;

    logic [MAX_WAYS-1:0]   hit_vec;
    logic [WAY_W-1:0]      hit_way;
    logic                  nd_v [2*LEAVES];
    logic [STAMP_BITS-1:0] nd_s [2*LEAVES];
    logic [WAY_W-1:0]      nd_w [2*LEAVES];

    always_comb begin
        hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            hit_vec[w] = (sacl_pkg::WAYS_CNT_W'(w) < i_ways) &&
                         (i_tags[w*sacl_pkg::TAG_W +: sacl_pkg::TAG_W] == i_tag);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
        end
    end

    // min tree; the right child wins only when strictly smaller, so ties
    // resolve to the lowest way
    always_comb begin
        for (int n = 0; n < 2*LEAVES; n++) begin
            nd_v[n] = 1'b0;
            nd_s[n] = '0;
            nd_w[n] = '0;
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            nd_v[LEAVES+i] = sacl_pkg::WAYS_CNT_W'(i) < i_ways;
            nd_s[LEAVES+i] = i_stamps[i*STAMP_BITS +: STAMP_BITS];
            nd_w[LEAVES+i] = WAY_W'(i);
        end
        for (int n = LEAVES - 1; n >= 1; n--) begin
            if (nd_v[2*n+1] && (!nd_v[2*n] || (nd_s[2*n+1] < nd_s[2*n]))) begin
                nd_v[n] = nd_v[2*n+1];
                nd_s[n] = nd_s[2*n+1];
                nd_w[n] = nd_w[2*n+1];
            end else begin
                nd_v[n] = nd_v[2*n];
                nd_s[n] = nd_s[2*n];
                nd_w[n] = nd_w[2*n];
            end
        end
    end

    assign o_hit = |hit_vec;
    assign o_way = o_hit ? hit_way : nd_w[1];

endmodule

// File: src/set_assoc_lru_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Handshake: the result is registered in the lookup state once the output can
// advance; a waiting result holds the lookup, and with it the input, until
// it is taken. A new item is taken only in the idle state, after the
// read-then-write of one set row in the tag and stamp RAMs for the last one.
// Reset: counters, configuration and the output valid flag clear; a clearing
// pass then zeroes the RAMs, one set per cycle over all 2**floor(log2(MAX_SETS))
// rows (at least 2), with no item taken.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_tags_defines.svh"

module set_assoc_lru_cache_tags #(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_BITS  = 32,
    parameter int STAMP_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sacl_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ADDR_BITS-1:0]               i_addr,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_miss,
    output logic [sacl_pkg::SET_OUT_W-1:0]     o_set_index,
    output logic [sacl_pkg::WAY_OUT_W-1:0]     o_way_index,
    output logic [sacl_pkg::TAG_W-1:0]         o_old_tag,
    output logic [sacl_pkg::CNT_W-1:0]         o_miss_total,
    output logic [sacl_pkg::CNT_W-1:0]         o_access_total
);

    localparam int MAX_IB   = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_W    = (MAX_IB > 0) ? MAX_IB : 1;
    localparam int ROWS     = 2 ** SET_W;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W    = sacl_pkg::TAG_W;
    localparam int CNT_W    = sacl_pkg::CNT_W;
    localparam int TROW_W   = MAX_WAYS * TAG_W;
    localparam int SROW_W   = MAX_WAYS * STAMP_BITS;
    localparam int SCMP_W   = (STAMP_BITS > CNT_W) ? STAMP_BITS : CNT_W;
    localparam int WCNT_W   = sacl_pkg::WAYS_CNT_W;

    localparam logic [sacl_pkg::CFG_W-1:0] MAX_IB_C   = sacl_pkg::CFG_W'(MAX_IB);
    localparam logic [WCNT_W-1:0]          MAX_WAYS_C = WCNT_W'(MAX_WAYS);
    localparam logic [SCMP_W-1:0]          SMAX_C     = SCMP_W'({STAMP_BITS{1'b1}});

    sacl_pkg::t_state r_state, n_state;

    logic [sacl_pkg::CFG_W-1:0] r_off, r_ib, r_ways;
    logic [SET_W-1:0]           r_clr;
    logic [SET_W-1:0]           r_set;
    logic [TAG_W-1:0]           r_tag;
    logic [CNT_W-1:0]           r_acc, r_miss_cnt;
    logic                       r_out_valid;
    logic                       r_miss;
    logic [SET_W-1:0]           r_set_o;
    logic [WAY_W-1:0]           r_way_o;
    logic [TAG_W-1:0]           r_old_tag;

    logic                       in_acc;
    logic                       advance;
    logic [sacl_pkg::CFG_W-1:0] ib_eff;
    logic [WCNT_W-1:0]          ways_eff;
    logic [ADDR_BITS-1:0]       line;
    logic [ADDR_BITS-1:0]       upper;
    logic [SET_W-1:0]           set_c;
    logic [TAG_W-1:0]           tag_c;

    logic [TROW_W-1:0]          rd_tags, wr_tags;
    logic [SROW_W-1:0]          rd_stamps, wr_stamps;
    logic                       ram_we;
    logic [SET_W-1:0]           ram_waddr;
    logic                       sel_hit;
    logic [WAY_W-1:0]           sel_way;
    logic [TAG_W-1:0]           old_tag;
    logic [CNT_W-1:0]           n_acc, n_miss_cnt;
    logic [SCMP_W-1:0]          acc_w;
    logic [STAMP_BITS-1:0]      stamp;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= sacl_pkg::RST_OFFSET_BITS;
            r_ib   <= sacl_pkg::RST_INDEX_BITS;
            r_ways <= sacl_pkg::RST_WAYS_IN_USE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sacl_pkg::CFG_OFFSET_BITS: r_off  <= i_cfg_data;
                sacl_pkg::CFG_INDEX_BITS:  r_ib   <= i_cfg_data;
                sacl_pkg::CFG_WAYS_IN_USE: r_ways <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // address split
    always_comb begin
        ib_eff   = (r_ib > MAX_IB_C) ? MAX_IB_C : r_ib;
        ways_eff = WCNT_W'(r_ways);
        if (ways_eff == '0) begin
            ways_eff = WCNT_W'(1);
        end else if (ways_eff > MAX_WAYS_C) begin
            ways_eff = MAX_WAYS_C;
        end
        line  = i_addr >> r_off;
        upper = line >> ib_eff;
        set_c = SET_W'(line) & ((SET_W'(1) << ib_eff) - SET_W'(1));
        tag_c = TAG_W'(upper);
    end

    assign in_acc  = i_in_valid && o_in_ready;
    assign advance = !r_out_valid || i_out_ready;

    sacl_ram #(.WIDTH(TROW_W), .DEPTH(ROWS), .AW(SET_W)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_tags),
        .i_re    (in_acc),
        .i_raddr (set_c),
        .o_rdata (rd_tags)
    );

    sacl_ram #(.WIDTH(SROW_W), .DEPTH(ROWS), .AW(SET_W)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_stamps),
        .i_re    (in_acc),
        .i_raddr (set_c),
        .o_rdata (rd_stamps)
    );

    sacl_way_sel #(.MAX_WAYS(MAX_WAYS), .STAMP_BITS(STAMP_BITS), .WAY_W(WAY_W)) u_way_sel (
        .i_tags   (rd_tags),
        .i_stamps (rd_stamps),
        .i_tag    (r_tag),
        .i_ways   (ways_eff),
        .o_hit    (sel_hit),
        .o_way    (sel_way)
    );

    // counters, stamp and row update
    always_comb begin
        n_acc      = (&r_acc) ? r_acc : r_acc + CNT_W'(1);
        n_miss_cnt = (sel_hit || (&r_miss_cnt)) ? r_miss_cnt : r_miss_cnt + CNT_W'(1);
        acc_w      = SCMP_W'(n_acc);
        stamp      = (acc_w > SMAX_C) ? {STAMP_BITS{1'b1}} : STAMP_BITS'(acc_w);
        old_tag    = '0;
        wr_tags    = rd_tags;
        wr_stamps  = rd_stamps;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == sel_way) begin
                old_tag = rd_tags[w*TAG_W +: TAG_W];
                if (!sel_hit) begin
                    wr_tags[w*TAG_W +: TAG_W] = r_tag;
                end
                wr_stamps[w*STAMP_BITS +: STAMP_BITS] = stamp;
            end
        end
        if (r_state == sacl_pkg::ST_CLEAR) begin
            wr_tags   = '0;
            wr_stamps = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_set;
        unique case (r_state)
            sacl_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (&r_clr) begin
                    n_state = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = sacl_pkg::ST_LOOK;
                end
            end
            sacl_pkg::ST_LOOK: begin
                if (advance) begin
                    ram_we  = 1'b1;
                    n_state = sacl_pkg::ST_IDLE;
                end
            end
            default: n_state = sacl_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_acc       <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == sacl_pkg::ST_CLEAR) begin
                r_clr <= r_clr + SET_W'(1);
            end
            if (r_state == sacl_pkg::ST_LOOK && advance) begin
                r_acc       <= n_acc;
                r_miss_cnt  <= n_miss_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_set <= set_c;
            r_tag <= tag_c;
        end
        if (r_state == sacl_pkg::ST_LOOK && advance) begin
            r_miss    <= !sel_hit;
            r_set_o   <= r_set;
            r_way_o   <= sel_way;
            r_old_tag <= old_tag;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_miss         = r_miss;
    assign o_set_index    = sacl_pkg::SET_OUT_W'(r_set_o);
    assign o_way_index    = sacl_pkg::WAY_OUT_W'(r_way_o);
    assign o_old_tag      = r_old_tag;
    assign o_miss_total   = r_miss_cnt;
    assign o_access_total = r_acc;

    `SACL_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_acc, !o_in_ready, "item accepted while busy")
    `SACL_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, r_state == sacl_pkg::ST_LOOK && !r_out_valid, r_out_valid, "result not loaded")
    `SACL_ASSERT(a_miss_le_acc, i_clk, i_rst_n, r_miss_cnt <= r_acc, "miss count above access count")
    `SACL_ASSERT_NEXT(a_acc_moves, i_clk, i_rst_n, r_state == sacl_pkg::ST_LOOK && advance, r_acc != $past(r_acc) || (&r_acc), "access count did not advance")

endmodule
